// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion that is switched off while reset is held
`define STBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that is also checked during reset
`define STBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// shared constants of the sorted table binary search block
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 9;
    localparam int DATA_W      = 32;
    localparam int SLOT_W      = 8;
    localparam int TDATA_W     = 72;
    localparam int ENTRY_W     = 2 * DATA_W;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

endpackage

// ===== src/stbs_ram.sv =====
// ----------------------------------------------------------------------------
// stbs_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// price table in a ram with exact-match binary search
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser is the action, 0 loads one slot, 1 searches.
// A load writes code and price into the slot and gives no result.
// A search probes slots 0 .. entries_in_use-1, which software keeps sorted
// ascending by price, and returns exactly one transaction on m_axis: tuser is
// found, tdata the slot, code and price of the match, all zero on a miss.
// entries_in_use is written on the cfg channel, which is always ready;
// values above 256 act as 256.
// The ram read and the compare form one loop of one probe per cycle, and
// an empty range skips the ram and goes straight to a miss. The result lands
// in an output register; the next transaction is accepted while it still
// waits to be taken.
// If the receiver stalls while the output register is full, a finished search
// holds with the ram read data frozen until the register drains.
// Reset clears the range to 0 and the control state; table contents are
// undefined until loaded, and no clearing pass is run.
// ----------------------------------------------------------------------------
module sorted_table_binary_search import stbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CNT_W-1:0]   i_cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // slot, product_code, price
    input  logic               s_axis_tuser,   // action
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // match_slot, match_code, match_price
    output logic               m_axis_tuser    // found
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SRCH = 3'b010,
        S_MISS = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_lo, n_lo;
    logic [CNT_W-1:0]         r_end, n_end;
    logic [ADDR_W-1:0]        r_mid, n_mid;
    logic signed [DATA_W-1:0] r_want, n_want;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_found, n_out_found;
    logic [SLOT_W-1:0]        r_out_slot, n_out_slot;
    logic [DATA_W-1:0]        r_out_code, n_out_code;
    logic [DATA_W-1:0]        r_out_price, n_out_price;

    logic                     ram_we;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic [SLOT_W-1:0]        in_slot;
    logic [DATA_W-1:0]        in_code;
    logic [DATA_W-1:0]        in_price;
    logic signed [DATA_W-1:0] have;
    logic                     hit;
    logic                     above;
    logic [CNT_W-1:0]         lo_nx;
    logic [CNT_W-1:0]         end_nx;
    logic [CNT_W:0]           mid_sum;
    logic [CNT_W:0]           init_sum;
    logic                     out_free;

    assign in_slot  = s_axis_tdata[SLOT_W-1:0];
    assign in_code  = s_axis_tdata[SLOT_W +: DATA_W];
    assign in_price = s_axis_tdata[SLOT_W+DATA_W +: DATA_W];

    stbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_slot[ADDR_W-1:0]),
        .i_wdata ({in_code, in_price}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign have     = signed'(ram_rdata[DATA_W-1:0]);
    assign hit      = (have == r_want);
    assign above    = (have > r_want);
    assign lo_nx    = above ? r_lo : (CNT_W'(r_mid) + CNT_W'(1));
    assign end_nx   = above ? CNT_W'(r_mid) : r_end;
    assign mid_sum  = {1'b0, lo_nx} + {1'b0, end_nx} - (CNT_W+1)'(1);
    assign init_sum = {1'b0, r_count} - (CNT_W+1)'(1);
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_end       = r_end;
        n_mid       = r_mid;
        n_want      = r_want;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_found = r_out_found;
        n_out_slot  = r_out_slot;
        n_out_code  = r_out_code;
        n_out_price = r_out_price;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_mid;

        if (i_cfg_valid) begin
            n_count = (i_cfg_data > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == ACT_LOAD) begin
                        ram_we = 1'b1;
                    end else begin
                        n_want = signed'(in_price);
                        if (r_count == '0) begin
                            n_state = S_MISS;
                        end else begin
                            n_lo      = '0;
                            n_end     = r_count;
                            n_mid     = init_sum[ADDR_W:1];
                            ram_re    = 1'b1;
                            ram_raddr = init_sum[ADDR_W:1];
                            n_state   = S_SRCH;
                        end
                    end
                end
            end
            S_SRCH: begin
                if (hit) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_found = 1'b1;
                        n_out_slot  = SLOT_W'(r_mid);
                        n_out_code  = ram_rdata[ENTRY_W-1:DATA_W];
                        n_out_price = ram_rdata[DATA_W-1:0];
                        n_state     = S_IDLE;
                    end
                end else if (lo_nx >= end_nx) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_found = 1'b0;
                        n_out_slot  = '0;
                        n_out_code  = '0;
                        n_out_price = '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_lo      = lo_nx;
                    n_end     = end_nx;
                    n_mid     = mid_sum[ADDR_W:1];
                    ram_re    = 1'b1;
                    ram_raddr = mid_sum[ADDR_W:1];
                end
            end
            S_MISS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = 1'b0;
                    n_out_slot  = '0;
                    n_out_code  = '0;
                    n_out_price = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_end       <= n_end;
        r_mid       <= n_mid;
        r_want      <= n_want;
        r_out_found <= n_out_found;
        r_out_slot  <= n_out_slot;
        r_out_code  <= n_out_code;
        r_out_price <= n_out_price;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = {r_out_price, r_out_code, r_out_slot};

endmodule

// ===== src/stbs_checker.sv =====
// ----------------------------------------------------------------------------
// stbs_checker
// port-level checks of the sorted table binary search block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stbs_checker import stbs_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [CNT_W-1:0]   i_cfg_data,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [TDATA_W-1:0] s_axis_tdata,
    input logic               s_axis_tuser,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser
);

    logic search_acc;
    logic load_acc;
    logic cfg_seen;

    assign search_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_SEARCH);
    assign load_acc   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_LOAD);
    assign cfg_seen   = i_cfg_valid && o_cfg_ready && (i_cfg_data != '0);

    `STBS_ASSERT_ALWAYS(a_out_idle_after_reset, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")
    `STBS_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `STBS_ASSERT(a_miss_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0, "miss result carries data")
    `STBS_ASSERT(a_search_busy, i_clk, i_rst_n, search_acc |=> !s_axis_tready, "search did not block input")
    `STBS_ASSERT(a_load_ready, i_clk, i_rst_n, load_acc && !cfg_seen |=> s_axis_tready, "load stalled the input")

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);
